// ----- hdl/exp_of_nonpositive_float32_core_defines.svh -----
// Assertion macros shared by the exp core.
`ifndef EXP_OF_NONPOSITIVE_FLOAT32_CORE_DEFINES_SVH
`define EXP_OF_NONPOSITIVE_FLOAT32_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define EXP_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("exp core implication check failed");

// Next-cycle implication, checked outside reset.
`define EXP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("exp core next-cycle check failed");

`endif

// ----- hdl/expnp_pkg.sv -----
`timescale 1ns / 1ps
package expnp_pkg;

   // Number of floating-point steps in the operation chain; each step has two stages.
   localparam int Steps = 16;
   localparam int Latency = 2 * Steps + 1;

   // Binary32 constants of the approximation.
   localparam logic [31:0] MAGIC_BIAS  = 32'h4B40007F;
   localparam logic [31:0] NEG_BIAS    = 32'hCB40007F;
   localparam logic [31:0] LOG2E       = 32'h3FB8AA3B;
   localparam logic [31:0] M_LN2_HI    = 32'hBF317200;
   localparam logic [31:0] M_LN2_LO    = 32'hB5BFBE8E;
   localparam logic [31:0] COEF_C1     = 32'h3F7FFFFB;
   localparam logic [31:0] COEF_C2     = 32'h3EFFFEE3;
   localparam logic [31:0] COEF_C3     = 32'h3E2AAD40;
   localparam logic [31:0] COEF_C4     = 32'h3D2B9D0D;
   localparam logic [31:0] COEF_C5     = 32'h3C07CFCE;
   localparam logic [30:0] CUTOFF_MAG  = 31'h42AEAC4F;
   localparam logic [31:0] QUIET_BIT   = 32'h00400000;
   localparam logic [31:0] DEFAULT_NAN = 32'hFFC00000;
   localparam logic [31:0] QNAN        = 32'h7FC00000;

   // Unrounded operation result: value = mag * 2^e, or a finished special pattern.
   typedef struct packed {
      logic               spec;
      logic [31:0]        spec_bits;
      logic               sgn;
      logic signed [11:0] e;
      logic [49:0]        mag;
   } raw_type;

   // Values carried along the pipeline with each item.
   typedef struct packed {
      logic        last;
      logic [31:0] x;
      logic [31:0] s;
      logic [31:0] t;
      logic [31:0] ts;
      logic [31:0] p;
      logic [31:0] l;
   } carry_type;

   function automatic logic is_nan(logic [31:0] a);
      return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
   endfunction

   function automatic logic is_inf(logic [31:0] a);
      return (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
   endfunction

   function automatic logic is_zero(logic [31:0] a);
      return a[30:0] == 31'd0;
   endfunction

   // Exact product of two binary32 values, before rounding.
   function automatic raw_type fp_mul_raw(logic [31:0] a, logic [31:0] b);
      raw_type            r;
      logic [7:0]         ea;
      logic [7:0]         eb;
      logic signed [11:0] sa;
      logic signed [11:0] sb;
      logic [23:0]        ma;
      logic [23:0]        mb;
      logic [47:0]        prod;
      r = '0;
      ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
      eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
      sa = $signed({4'b0, ea});
      sb = $signed({4'b0, eb});
      ma = {a[30:23] != 8'd0, a[22:0]};
      mb = {b[30:23] != 8'd0, b[22:0]};
      prod = '0;
      r.sgn = a[31] ^ b[31];
      if (is_nan(a) || is_nan(b)) begin
         r.spec = 1'b1;
         r.spec_bits = QNAN;
      end else if ((is_inf(a) && is_zero(b)) || (is_zero(a) && is_inf(b))) begin
         r.spec = 1'b1;
         r.spec_bits = QNAN;
      end else if (is_inf(a) || is_inf(b)) begin
         r.spec = 1'b1;
         r.spec_bits = {a[31] ^ b[31], 8'hFF, 23'd0};
      end else begin
         // The full 48-bit product of the two significands.
         prod = ma * mb;
         r.e = sa + sb - 12'sd300;
         r.mag = {2'b0, prod};
      end
      return r;
   endfunction

   // Aligned sum of two binary32 values with guard, round and sticky bits.
   function automatic raw_type fp_add_raw(logic [31:0] a, logic [31:0] b);
      raw_type     r;
      logic [31:0] big;
      logic [31:0] sml;
      logic [7:0]  eb;
      logic [7:0]  es;
      logic [23:0] ms;
      logic [7:0]  d;
      logic [4:0]  dc;
      logic [53:0] full;
      logic [26:0] al;
      logic [27:0] sum;
      r = '0;
      if (a[30:0] >= b[30:0]) begin
         big = a;
         sml = b;
      end else begin
         big = b;
         sml = a;
      end
      eb = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
      es = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
      ms = {sml[30:23] != 8'd0, sml[22:0]};
      d = eb - es;
      dc = (d > 8'd27) ? 5'd27 : d[4:0];
      full = {ms, 3'b0, 27'd0} >> dc;
      al = full[53:27] | {26'd0, |full[26:0]};
      if (big[31] == sml[31]) begin
         sum = {1'b0, big[30:23] != 8'd0, big[22:0], 3'b0} + {1'b0, al};
      end else begin
         sum = {1'b0, big[30:23] != 8'd0, big[22:0], 3'b0} - {1'b0, al};
      end
      if (is_nan(a) || is_nan(b)) begin
         r.spec = 1'b1;
         r.spec_bits = QNAN;
      end else if (is_inf(a) && is_inf(b) && (a[31] != b[31])) begin
         r.spec = 1'b1;
         r.spec_bits = QNAN;
      end else if (is_inf(a)) begin
         r.spec = 1'b1;
         r.spec_bits = a;
      end else if (is_inf(b)) begin
         r.spec = 1'b1;
         r.spec_bits = b;
      end else begin
         // An exact zero sum is +0 unless both operands are -0.
         r.sgn = (sum == 28'd0) ? (a[31] & b[31]) : big[31];
         r.e = $signed({4'b0, eb}) - 12'sd153;
         r.mag = {22'd0, sum};
      end
      return r;
   endfunction

   // Normalize and round to nearest even, keeping subnormals.
   function automatic logic [31:0] fp_round(raw_type r);
      logic [5:0]         p;
      logic signed [12:0] ee;
      logic signed [12:0] sh;
      logic signed [12:0] nsh;
      logic [99:0]        full;
      logic [23:0]        mant;
      logic               guard;
      logic               sticky;
      logic               normal;
      logic               rnd;
      logic [9:0]         field;
      logic [33:0]        total;
      logic [31:0]        res;
      p = '0;
      for (int i = 0; i < 50; i++) begin
         if (r.mag[i]) begin
            p = 6'(i);
         end
      end
      ee = $signed({7'b0, p}) + {r.e[11], r.e};
      normal = (ee >= -13'sd126);
      sh = normal ? ($signed({7'b0, p}) - 13'sd23) : (-13'sd149 - {r.e[11], r.e});
      nsh = -sh;
      full = '0;
      mant = '0;
      guard = 1'b0;
      sticky = 1'b0;
      if (sh > 13'sd50) begin
         sticky = |r.mag;
      end else if (sh >= 13'sd0) begin
         full = {r.mag, 50'd0} >> sh[5:0];
         mant = full[73:50];
         guard = full[49];
         sticky = |full[48:0];
      end else begin
         mant = 24'(r.mag << nsh[4:0]);
      end
      rnd = guard & (sticky | mant[0]);
      field = normal ? 10'(ee + 13'sd126) : 10'd0;
      total = {1'b0, field, 23'd0} + {10'd0, mant} + {33'd0, rnd};
      if (r.spec) begin
         res = r.spec_bits;
      end else if (r.mag == 50'd0) begin
         res = {r.sgn, 31'd0};
      end else if (total >= 34'h07F800000) begin
         res = {r.sgn, 8'hFF, 23'd0};
      end else begin
         res = {r.sgn, total[30:0]};
      end
      return res;
   endfunction

   // Main operation of each step.
   function automatic raw_type step_op0(int k, carry_type c);
      raw_type r;
      unique case (k)
         0:       r = fp_mul_raw(c.x, LOG2E);
         1:       r = fp_add_raw(c.p, MAGIC_BIAS);
         2:       r = fp_add_raw(c.p, NEG_BIAS);
         3:       r = fp_mul_raw(c.p, M_LN2_HI);
         4:       r = fp_add_raw(c.t, c.x);
         5:       r = fp_add_raw(c.l, c.t);
         6:       r = fp_mul_raw(COEF_C5, c.t);
         7:       r = fp_add_raw(c.p, COEF_C4);
         9:       r = fp_add_raw(c.p, COEF_C3);
         11:      r = fp_add_raw(c.p, COEF_C2);
         13:      r = fp_add_raw(c.p, COEF_C1);
         8, 10, 12: r = fp_mul_raw(c.p, c.t);
         14:      r = fp_mul_raw(c.ts, c.p);
         15:      r = fp_add_raw(c.p, c.s);
         default: r = '0;
      endcase
      return r;
   endfunction

   // Side operation of the two steps that run a second unit.
   function automatic raw_type step_op1(int k, carry_type c);
      raw_type r;
      unique case (k)
         3:       r = fp_mul_raw(c.p, M_LN2_LO);
         7:       r = fp_mul_raw(c.t, c.s);
         default: r = '0;
      endcase
      return r;
   endfunction

   // Round the step results and place them in the carried values.
   function automatic carry_type step_write(int k, carry_type c, raw_type r0, raw_type r1);
      carry_type res;
      logic [31:0] y0;
      res = c;
      y0 = fp_round(r0);
      unique case (k)
         2: begin
            res.s = {c.p[8:0], 23'd0};
            res.p = y0;
         end
         3: begin
            res.t = y0;
            res.l = fp_round(r1);
         end
         4, 5: begin
            res.t = y0;
         end
         7: begin
            res.p = y0;
            res.ts = fp_round(r1);
         end
         default: begin
            res.p = y0;
         end
      endcase
      return res;
   endfunction

endpackage

// ----- hdl/exp_of_nonpositive_float32_core.sv -----
// Each accepted item yields a result, shown with rsp_valid high for one cycle.
// Throughput: one item per cycle while busy is low; sixteen float steps of two stages
// each plus an output register, every step an operand-stage (multiply or align-add) then
// a normalize-round stage. busy is a registered copy of reset; the pipeline never stalls.
// Reset (synchronous) clears all valid bits; items in flight are dropped.
`timescale 1ns / 1ps
`include "exp_of_nonpositive_float32_core_defines.svh"
module exp_of_nonpositive_float32_core
   import expnp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_x_bits,
   input  logic        req_last_in,
   output logic        rsp_valid,
   output logic [31:0] rsp_y_bits,
   output logic        rsp_last_out
);

   carry_type   a_ff [Steps];
   carry_type   b_ff [Steps];
   raw_type     r0_ff [Steps];
   raw_type     r1_ff [Steps];
   logic        va_ff [Steps];
   logic        vb_ff [Steps];
   carry_type   entry_in;
   logic        accept;
   logic        busy_ff;
   logic        rsp_valid_ff;
   logic [31:0] y_ff;
   logic [31:0] y_in;
   logic        last_ff;

   // Busy is a registered copy of reset.
   always_ff @(posedge clock) begin
      busy_ff <= reset;
   end

   assign busy = busy_ff;
   assign accept = start && !busy_ff;

   // Build the carried values of a new item.
   always_comb begin
      entry_in = '0;
      entry_in.x = req_x_bits;
      entry_in.last = req_last_in;
   end

   // One operand stage and one rounding stage per float step.
   for (genvar k = 0; k < Steps; k++) begin : g_step
      carry_type step_in;
      logic      step_v_in;

      if (k == 0) begin : g_first
         assign step_in = entry_in;
         assign step_v_in = accept;
      end else begin : g_next
         assign step_in = b_ff[k-1];
         assign step_v_in = vb_ff[k-1];
      end

      always_ff @(posedge clock) begin
         a_ff[k] <= step_in;
         r0_ff[k] <= step_op0(k, step_in);
         r1_ff[k] <= step_op1(k, step_in);
         b_ff[k] <= step_write(k, a_ff[k], r0_ff[k], r1_ff[k]);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            va_ff[k] <= 1'b0;
            vb_ff[k] <= 1'b0;
         end else begin
            va_ff[k] <= step_v_in;
            vb_ff[k] <= va_ff[k];
         end
      end
   end

   // Final fix-ups: NaN argument, cutoff, generated NaN.
   always_comb begin
      priority if (is_nan(b_ff[Steps-1].x)) begin
         y_in = b_ff[Steps-1].x | QUIET_BIT;
      end else if (b_ff[Steps-1].x[31] && (b_ff[Steps-1].x[30:0] > CUTOFF_MAG)) begin
         y_in = 32'd0;
      end else if (is_nan(b_ff[Steps-1].p)) begin
         y_in = DEFAULT_NAN;
      end else begin
         y_in = b_ff[Steps-1].p;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= vb_ff[Steps-1];
      end
      y_ff <= y_in;
      last_ff <= b_ff[Steps-1].last;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_y_bits = y_ff;
   assign rsp_last_out = last_ff;

   // Every accepted item comes out after the fixed latency, and only then.
   `EXP_ASSERT_IMP(a_latency, clock, reset, accept, ##Latency rsp_valid)
   `EXP_ASSERT_IMP(a_no_spurious, clock, reset, rsp_valid, $past(accept, Latency))
   // Any NaN delivered is quiet.
   `EXP_ASSERT_IMP(a_quiet_nan, clock, reset,
      rsp_valid && (rsp_y_bits[30:23] == 8'hFF) && (rsp_y_bits[22:0] != 23'd0),
      rsp_y_bits[22])
   // The last step hands its valid bit to the output register.
   `EXP_ASSERT_NEXT(a_out_follow, clock, reset, vb_ff[Steps-1], rsp_valid)

endmodule
